/* hdl/dxfc_pkg.sv */
// Shared constants and types for the binary64 / 80-bit extended converter.
// No dependencies; imported by dxfc_convert, double_extended_float_converter and tb_top.
`timescale 1ns / 1ps
`default_nettype none

package dxfc_pkg;

    // Beat widths
    localparam int FRAC_W  = 64;
    localparam int WORD_W  = 16;
    localparam int DATA_W  = FRAC_W + WORD_W;

    // Field widths of the two formats
    localparam int F52_W   = 52;
    localparam int E11_W   = 11;
    localparam int E15_W   = 15;

    localparam logic [E11_W-1:0] EXP11_ALL = 11'h7ff;
    localparam logic [E15_W-1:0] EXP15_ALL = 15'h7fff;

    // Bias difference 16383 - 1023
    localparam logic [E15_W-1:0] REBIAS           = 15'd15360;
    // Narrowing thresholds on the 15-bit exponent
    localparam logic [E15_W-1:0] NARROW_MIN_NORM  = 15'd15361;  // rebiased exponent 1
    localparam logic [E15_W-1:0] NARROW_OVF       = 15'd17407;  // rebiased exponent 0x7ff
    localparam logic [E15_W-1:0] NARROW_MIN_DENRM = 15'd15298;  // shift of 63

    typedef enum logic
    {
        ACT_WIDEN  = 1'b0,
        ACT_NARROW = 1'b1
    } action_t;

endpackage

`default_nettype wire

/* hdl/dxfc_convert.sv */
// Combinational conversion of one beat between binary64 and 80-bit extended.
// Depends on dxfc_pkg for field widths, exponent constants and action codes.
`timescale 1ns / 1ps
`default_nettype none

module dxfc_convert
    import dxfc_pkg::*;
(
    input  wire action_t            action,
    input  wire logic [FRAC_W-1:0]  value_low,
    input  wire logic [WORD_W-1:0]  value_high,
    output logic      [FRAC_W-1:0]  result_low,
    output logic      [WORD_W-1:0]  result_high
);

    // Widening fields
    logic              w_sign;
    logic [E11_W-1:0]  w_exp;
    logic [F52_W-1:0]  w_frac;
    logic [FRAC_W-1:0] w_norm;
    logic [5:0]        w_lz;
    logic [FRAC_W-1:0] w_low;
    logic [E15_W-1:0]  w_exp15;

    // Narrowing fields
    logic              n_sign;
    logic [E15_W-1:0]  n_exp;
    logic [F52_W-1:0]  n_frac;
    logic [E15_W-1:0]  n_rebiased;
    logic [E15_W-1:0]  n_shift;
    logic [F52_W:0]    n_denorm;
    logic [FRAC_W-1:0] n_low;

    assign w_sign = value_low[FRAC_W-1];
    assign w_exp  = value_low[FRAC_W-2 -: E11_W];
    assign w_frac = value_low[F52_W-1:0];

    // Normalize a denormal by binary search: six shift steps of 32..1
    always_comb
    begin
        w_norm = {w_frac, 12'b0};
        w_lz   = 6'd0;
        if (w_norm[63:32] == '0)
        begin
            w_norm = {w_norm[31:0], 32'b0};
            w_lz   = w_lz | 6'd32;
        end
        if (w_norm[63:48] == '0)
        begin
            w_norm = {w_norm[47:0], 16'b0};
            w_lz   = w_lz | 6'd16;
        end
        if (w_norm[63:56] == '0)
        begin
            w_norm = {w_norm[55:0], 8'b0};
            w_lz   = w_lz | 6'd8;
        end
        if (w_norm[63:60] == '0)
        begin
            w_norm = {w_norm[59:0], 4'b0};
            w_lz   = w_lz | 6'd4;
        end
        if (w_norm[63:62] == '0)
        begin
            w_norm = {w_norm[61:0], 2'b0};
            w_lz   = w_lz | 6'd2;
        end
        if (!w_norm[63])
        begin
            w_norm = {w_norm[62:0], 1'b0};
            w_lz   = w_lz | 6'd1;
        end
    end

    always_comb
    begin
        if (w_exp == EXP11_ALL)
        begin
            w_exp15 = EXP15_ALL;
            w_low   = {w_frac, 12'b0};
        end
        else if (w_exp == '0)
        begin
            if (w_frac == '0)
            begin
                w_exp15 = '0;
                w_low   = '0;
            end
            else
            begin
                // drop the leading one into the hidden bit
                w_exp15 = REBIAS - {9'b0, w_lz};
                w_low   = {w_norm[62:0], 1'b0};
            end
        end
        else
        begin
            w_exp15 = {4'b0, w_exp} + REBIAS;
            w_low   = {w_frac, 12'b0};
        end
    end

    assign n_sign     = value_high[WORD_W-1];
    assign n_exp      = value_high[E15_W-1:0];
    assign n_frac     = value_low[FRAC_W-1:FRAC_W-F52_W];
    assign n_rebiased = n_exp - REBIAS;
    assign n_shift    = NARROW_MIN_NORM - n_exp;
    assign n_denorm   = {1'b1, n_frac} >> n_shift[5:0];

    always_comb
    begin
        if (n_exp == EXP15_ALL)
            n_low = {n_sign, EXP11_ALL, n_frac};
        else if (n_exp == '0)
            n_low = {n_sign, 63'b0};
        else if (n_exp >= NARROW_OVF)
            n_low = {n_sign, EXP11_ALL, 52'b0};
        else if (n_exp >= NARROW_MIN_NORM)
            n_low = {n_sign, n_rebiased[E11_W-1:0], n_frac};
        else if (n_exp >= NARROW_MIN_DENRM)
            n_low = {n_sign, 10'b0, n_denorm};
        else
            n_low = {n_sign, 63'b0};
    end

    always_comb
    begin
        case (action)
            ACT_WIDEN:
            begin
                result_low  = w_low;
                result_high = {w_sign, w_exp15};
            end
            ACT_NARROW:
            begin
                result_low  = n_low;
                result_high = '0;
            end
            default:
            begin
                result_low  = '0;
                result_high = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/double_extended_float_converter.sv */
// Top level of the binary64 / 80-bit extended converter: input register,
// conversion logic and result register. Depends on dxfc_pkg and dxfc_convert.
//
// Usage:
//   s_axis carries one value per beat: tuser selects the direction
//   (0 widen binary64 to 80-bit, 1 narrow 80-bit to binary64), tdata holds
//   value_low in bits 63:0 and value_high in bits 79:64.
//   m_axis returns one beat per input beat, in order: result_low in bits
//   63:0, result_high in bits 79:64 (zero after narrowing).
//   Path: an accepted beat passes through the input register, then the
//   result register, before it is presented on m_axis.
//   Throughput: one beat per cycle while m_axis_tready is high; the
//   conversion is a single pass of logic between the two registers, with a
//   six-step normalizing shift as its longest path.
//   Reset clears both valid flags; nothing else needs initializing.
//   When m_axis_tready is low, the result register holds and the input
//   register fills; s_axis_tready drops only once both are occupied.
//
`timescale 1ns / 1ps
`default_nettype none

module double_extended_float_converter
    import dxfc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [DATA_W-1:0] s_axis_tdata,   // value_low [63:0], value_high [79:64]
    input  wire logic              s_axis_tuser,   // action [0]

    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [DATA_W-1:0] m_axis_tdata    // result_low [63:0], result_high [79:64]
);

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [DATA_W-1:0] in_data_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic              out_load;
    logic              in_load;
    logic [FRAC_W-1:0] conv_low;
    logic [WORD_W-1:0] conv_high;

    // Advance the input register into the result register whenever it is free
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    dxfc_convert u_convert
    (
        .action      (action_t'(in_action_reg)),
        .value_low   (in_data_reg[FRAC_W-1:0]),
        .value_high  (in_data_reg[DATA_W-1:FRAC_W]),
        .result_low  (conv_low),
        .result_high (conv_high)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_load)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_action_reg <= s_axis_tuser;
            in_data_reg   <= s_axis_tdata;
        end
        if (out_load && in_valid_reg)
            out_data_reg <= {conv_high, conv_low};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking bench for double_extended_float_converter: directed and random
// binary64 / 80-bit conversions in both directions, checked by a scoreboard.
// Depends on dxfc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
    import dxfc_pkg::*;

    class conversion_scoreboard;
        logic [DATA_W-1:0] expected_words[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Widen binary64 bits to {sign/exponent word, fraction}.
        function logic [DATA_W-1:0] widen_word(logic [63:0] bits);
            logic [63:0] frac;
            logic [E11_W-1:0] e;
            logic [E15_W-1:0] x;
            int lead;
            bit found;
            frac = {bits[F52_W-1:0], 12'h000};
            e = bits[62:52];
            lead = 0;
            found = 0;
            if (e == EXP11_ALL)
            begin
                x = EXP15_ALL;
            end
            else if (e == '0)
            begin
                if (frac == '0)
                begin
                    x = '0;
                end
                else
                begin
                    for (int i = 63; i >= 0; i--)
                    begin
                        if (!found && frac[i])
                        begin
                            found = 1;
                            lead = 63 - i;
                        end
                    end
                    // shift out the leading one too: it becomes the hidden bit
                    frac = frac << (lead + 1);
                    x = E15_W'(int'(REBIAS) + 1 - (lead + 1));
                end
            end
            else
            begin
                x = E15_W'(int'(e) + int'(REBIAS));
            end
            return {bits[63], x, frac};
        endfunction

        // Narrow {word, fraction} to binary64 bits; the high word is zero.
        function logic [DATA_W-1:0] narrow_word(logic [63:0] frac80, logic [15:0] word);
            logic [E15_W-1:0] e;
            logic [F52_W-1:0] frac;
            logic [63:0] m;
            logic sign;
            int r;
            int sh;
            e = word[14:0];
            sign = word[15];
            frac = frac80[63:12];
            r = int'(e) - int'(REBIAS);
            if (e == EXP15_ALL)
                return {16'h0000, sign, EXP11_ALL, frac};
            if (e == '0)
                return {16'h0000, sign, 63'd0};
            if (r >= int'(EXP11_ALL))
                return {16'h0000, sign, EXP11_ALL, 52'd0};
            if (r >= 1)
                return {16'h0000, sign, r[E11_W-1:0], frac};
            sh = 1 - r;
            m = {11'd0, 1'b1, frac};
            m = (sh < 64) ? (m >> sh) : 64'd0;
            return {16'h0000, sign, m[62:0]};
        endfunction

        function void note_input(action_t act, logic [63:0] lo, logic [15:0] hi);
            if (act == ACT_WIDEN)
                expected_words.push_back(widen_word(lo));
            else
                expected_words.push_back(narrow_word(lo, hi));
        endfunction

        task check_result(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("unexpected beat %h", got));
            end
            else
            begin
                want = expected_words.pop_front();
                if (got[63:0] !== want[63:0])
                    report($sformatf("result_low %h, want %h", got[63:0], want[63:0]));
                if (got[79:64] !== want[79:64])
                    report($sformatf("result_high %h, want %h", got[79:64], want[79:64]));
            end
        endtask

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;    // value_low [63:0], value_high [79:64]
    logic              s_axis_tuser;    // action [0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;    // result_low [63:0], result_high [79:64]

    conversion_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_rx;
    bit  pressure_req;

    double_extended_float_converter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // Receiver: random backpressure, forced low during a hold-off.
    always @(negedge clk)
    begin
        m_axis_tready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Long receiver hold-off so the block fills and stalls its input.
    initial
    begin
        wait (pressure_req);
        @(posedge clk);
        hold_rx = 1;
        repeat (60) @(posedge clk);
        hold_rx = 0;
    end

    // Call at a falling edge; returns at the falling edge after acceptance.
    task send_beat(action_t act, logic [63:0] lo, logic [15:0] hi);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(act, lo, hi);
        @(negedge clk);
    endtask

    task send_directed();
        send_beat(ACT_WIDEN,  64'h0000_0000_0000_0000, 16'h0000);
        send_beat(ACT_WIDEN,  64'h8000_0000_0000_0000, 16'hffff);
        send_beat(ACT_WIDEN,  64'h7ff0_0000_0000_0000, 16'h0000);
        send_beat(ACT_WIDEN,  64'hfff0_0000_0000_0000, 16'h0000);
        send_beat(ACT_WIDEN,  64'h7ff8_0000_0000_0001, 16'h0000);
        send_beat(ACT_WIDEN,  64'h0000_0000_0000_0001, 16'h0000);
        send_beat(ACT_WIDEN,  64'h800f_ffff_ffff_ffff, 16'h0000);
        send_beat(ACT_WIDEN,  64'h0010_0000_0000_0000, 16'h0000);
        send_beat(ACT_WIDEN,  64'h7fef_ffff_ffff_ffff, 16'h0000);
        send_beat(ACT_WIDEN,  64'h3ff0_0000_0000_0000, 16'h0000);
        send_beat(ACT_WIDEN,  64'hffff_ffff_ffff_ffff, 16'hffff);
        // NaN payload only in the dropped low bits narrows to infinity
        send_beat(ACT_NARROW, 64'h0000_0000_0000_0fff, {1'b0, EXP15_ALL});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, 16'hffff);
        send_beat(ACT_NARROW, 64'h1234_5678_9abc_def0, 16'h8000);
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, 16'h0000);
        send_beat(ACT_NARROW, 64'h0000_0000_0000_0000, {1'b0, NARROW_OVF});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, {1'b1, NARROW_OVF - 15'd1});
        send_beat(ACT_NARROW, 64'h0000_0000_0000_0000, {1'b0, NARROW_MIN_NORM});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, {1'b1, REBIAS});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, {1'b0, NARROW_MIN_DENRM});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, {1'b0, NARROW_MIN_DENRM - 15'd1});
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, 16'h0001);
        send_beat(ACT_NARROW, 64'h8000_0000_0000_0000, 16'h3fff);
        send_beat(ACT_NARROW, 64'hffff_ffff_ffff_ffff, 16'h7ffe);
    endtask

    function logic [63:0] random_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0: v[62:0] = {11'd0, v[51:0] >> $urandom_range(51)};
            1: v[62:52] = EXP11_ALL;
            2: v[62:0] = '0;
            3: v[62:52] = (v[52]) ? 11'h001 : 11'h7fe;
            default: ;
        endcase
        return v;
    endfunction

    function logic [15:0] random_ext_word();
        logic [E15_W-1:0] e;
        case ($urandom_range(9))
            0: e = '0;
            1: e = EXP15_ALL;
            2: e = E15_W'($urandom_range(int'(NARROW_MIN_DENRM) - 1, 1));
            3: e = E15_W'($urandom_range(int'(NARROW_MIN_NORM), int'(NARROW_MIN_DENRM) - 2));
            4: e = E15_W'($urandom_range(int'(NARROW_OVF) + 8, int'(NARROW_OVF) - 8));
            5: e = E15_W'($urandom_range(int'(EXP15_ALL) - 1, int'(NARROW_OVF)));
            default: e = E15_W'($urandom_range(int'(NARROW_OVF) - 1, int'(NARROW_MIN_NORM)));
        endcase
        return {1'($urandom), e};
    endfunction

    task send_random(int count);
        logic [63:0] lo;
        logic [15:0] hi;
        repeat (count)
        begin
            if ($urandom_range(1) == 0)
            begin
                send_beat(ACT_WIDEN, random_double(), 16'($urandom));
            end
            else
            begin
                lo = {$urandom, $urandom};
                if ($urandom_range(7) == 0)
                    lo = lo & 64'h0000_0000_0000_0fff;
                hi = random_ext_word();
                send_beat(ACT_NARROW, lo, hi);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= 1'b0;
        pressure_req = 0;
        tx_idle_pct = 10;
        rx_idle_pct = 61;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_directed();
        send_random(200);

        tx_idle_pct = 61;
        rx_idle_pct = 10;
        send_random(215);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_req = 1;
        send_random(215);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
